[rtl/core/rsas_pkg.sv]
// ----------------------------------------------------------------------------
// Rotated sorted array search: shared package
// Widths, handshake field layout, controller states and the command and
// status bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package rsas_pkg;

    localparam int DATA_W      = 32;
    localparam int POS_W       = 10;
    localparam int DEPTH_DEF   = 1024;
    localparam int S_TDATA_W   = 32;
    localparam int S_TUSER_W   = 2;
    localparam int M_TDATA_W   = 16;
    localparam int M_TUSER_W   = 1;

    typedef enum logic {
        OP_LOAD   = 1'b0,
        OP_SEARCH = 1'b1
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HEAD,
        ST_ROT_RD,
        ST_ROT_CMP,
        ST_PICK,
        ST_LB_RD,
        ST_LB_CMP,
        ST_FIN_RD,
        ST_FIN_CMP,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        RD_ZERO,
        RD_MID,
        RD_LO
    } rd_sel_t;

    typedef struct packed {
        logic    capture;
        logic    wr;
        logic    res_clear;
        logic    res_ovf;
        logic    head_load;
        logic    rot_init;
        logic    rot_step;
        logic    pick;
        logic    lb_step;
        logic    res_check;
        logic    out_load;
        rd_sel_t rd_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic count_zero;
        logic count_full;
        logic lo_lt_hi;
        logic lo_lt_bound;
    } dp_status_t;

    // Address bits for a store of the given depth (at least one).
    function automatic int addr_bits(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

    // Bits for a count that runs from zero up to the depth itself.
    function automatic int count_bits(input int depth);
        return $clog2(depth + 1);
    endfunction

endpackage

[rtl/core/rotated_sorted_array_search_top.sv]
// ----------------------------------------------------------------------------
// Rotated sorted array search: top level
// Holds a rotated ascending array of signed elements and answers searches
// with two binary searches over the element store.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | tdata (lowest bit first)          | tuser (lowest bit first)
//  --------+-----------+-----------------------------------+-------------------------
//  s_      | in        | value[31:0]                       | op, first
//  m_      | out       | found, position[9:0], 5 zero bits | overflow
//
// A load is taken and the block stays ready for the next request, unless the
// store is full and a load not flagged first is dropped with an overflow result.
// A search runs two binary searches, for the rotation point and then a lower bound,
// and each probe is a store read followed by a compare.
// Reset empties the array but not the store. A result waits in its own register,
// so a stalled m_ side holds up the block only once the next result is ready too.
//
module rotated_sorted_array_search_top #(
    parameter int DEPTH = rsas_pkg::DEPTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Request channel.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [rsas_pkg::S_TDATA_W-1:0]  s_tdata,   // value[31:0]
    input  logic [rsas_pkg::S_TUSER_W-1:0]  s_tuser,   // [0] op, [1] first
    // Result channel.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [rsas_pkg::M_TDATA_W-1:0]  m_tdata,   // [0] found, [10:1] position
    output logic [rsas_pkg::M_TUSER_W-1:0]  m_tuser    // [0] overflow
);

    rsas_pkg::dp_cmd_t    cmd;
    rsas_pkg::dp_status_t status;
    rsas_pkg::op_t        s_op;
    logic                 s_first;

    assign s_op    = rsas_pkg::op_t'(s_tuser[0]);
    assign s_first = s_tuser[1];

    rsas_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_op     (s_op),
        .s_first  (s_first),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    rsas_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .value   (s_tdata[rsas_pkg::DATA_W-1:0]),
        .first   (s_first),
        .status  (status),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    logic s_accept;
    assign s_accept = s_tvalid && s_tready;

    // An overflow result never carries a hit or a position.
    a_ovf_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
        else $error("overflow result carries search data");

    // A stored load leaves the block ready for the next request.
    a_load_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && s_op == rsas_pkg::OP_LOAD && (s_first || !status.count_full)
        |=> s_tready)
        else $error("block busy after a stored load");

    // A dropped load must produce its overflow result before new requests.
    a_drop_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && s_op == rsas_pkg::OP_LOAD && !s_first && status.count_full
        |=> !s_tready)
        else $error("dropped load did not hold the request channel");

    // An accepted search always leaves the block busy, not ready for a new request.
    a_search_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && s_op == rsas_pkg::OP_SEARCH |=> !s_tready)
        else $error("request accepted while a search is running");

endmodule

[rtl/core/rsas_ram.sv]
// ----------------------------------------------------------------------------
// Rotated sorted array search: generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module rsas_ram #(
    parameter int WIDTH = rsas_pkg::DATA_W,
    parameter int DEPTH = rsas_pkg::DEPTH_DEF
) (
    input  logic                                 aclk,
    input  logic                                 we,
    input  logic [rsas_pkg::addr_bits(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic [rsas_pkg::addr_bits(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/rsas_dp.sv]
// ----------------------------------------------------------------------------
// Rotated sorted array search: datapath
// Element store, element count, search bounds, compares and result register.
// ----------------------------------------------------------------------------
module rsas_dp #(
    parameter int DEPTH = rsas_pkg::DEPTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  rsas_pkg::dp_cmd_t                cmd,
    input  logic [rsas_pkg::DATA_W-1:0]      value,
    input  logic                             first,
    output rsas_pkg::dp_status_t             status,
    output logic [rsas_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic [rsas_pkg::M_TUSER_W-1:0]   m_tuser
);

    localparam int AW = rsas_pkg::addr_bits(DEPTH);
    localparam int CW = rsas_pkg::count_bits(DEPTH);

    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] lo_reg, lo_next;
    logic [CW-1:0] hi_reg, hi_next;
    logic [CW-1:0] bound_reg, bound_next;
    logic [rsas_pkg::DATA_W-1:0] key_reg, head_reg;
    logic res_found_reg, res_found_next;
    logic [rsas_pkg::POS_W-1:0] res_pos_reg, res_pos_next;
    logic res_ovf_reg, res_ovf_next;
    logic out_found_reg;
    logic [rsas_pkg::POS_W-1:0] out_pos_reg;
    logic out_ovf_reg;

    logic [CW-1:0] diff, mid;
    logic [AW-1:0] waddr, raddr;
    logic [rsas_pkg::DATA_W-1:0] rdata;
    logic rd_ge_head, rd_lt_key, key_ge_head;

    assign diff = hi_reg - lo_reg;
    assign mid  = lo_reg + (diff >> 1);

    assign rd_ge_head  = $signed(rdata) >= $signed(head_reg);
    assign rd_lt_key   = $signed(rdata) < $signed(key_reg);
    assign key_ge_head = $signed(key_reg) >= $signed(head_reg);

    // A load flagged as first restarts the array at index zero.
    assign waddr = first ? '0 : count_reg[AW-1:0];

    always_comb begin
        unique case (cmd.rd_sel)
            rsas_pkg::RD_MID: raddr = mid[AW-1:0];
            rsas_pkg::RD_LO:  raddr = lo_reg[AW-1:0];
            default:          raddr = '0;
        endcase
    end

    rsas_ram #(
        .WIDTH (rsas_pkg::DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (cmd.wr),
        .waddr (waddr),
        .wdata (value),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb begin
        count_next = count_reg;
        if (cmd.wr) begin
            count_next = first ? CW'(1) : count_reg + CW'(1);
        end
    end

    always_comb begin
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        bound_next = bound_reg;
        if (cmd.rot_init) begin
            lo_next = '0;
            hi_next = count_reg;
        end else if (cmd.rot_step) begin
            if (rd_ge_head) begin
                lo_next = mid + CW'(1);
            end else begin
                hi_next = mid;
            end
        end else if (cmd.pick) begin
            // lo holds the rotation point here.
            if (key_ge_head) begin
                lo_next    = '0;
                hi_next    = lo_reg;
                bound_next = lo_reg;
            end else begin
                hi_next    = count_reg;
                bound_next = count_reg;
            end
        end else if (cmd.lb_step) begin
            if (rd_lt_key) begin
                lo_next = mid + CW'(1);
            end else begin
                hi_next = mid;
            end
        end
    end

    always_comb begin
        res_found_next = res_found_reg;
        res_pos_next   = res_pos_reg;
        res_ovf_next   = res_ovf_reg;
        if (cmd.res_clear) begin
            res_found_next = 1'b0;
            res_pos_next   = '0;
            res_ovf_next   = 1'b0;
        end else if (cmd.res_ovf) begin
            res_found_next = 1'b0;
            res_pos_next   = '0;
            res_ovf_next   = 1'b1;
        end else if (cmd.res_check) begin
            if (rdata == key_reg) begin
                res_found_next = 1'b1;
                res_pos_next   = rsas_pkg::POS_W'(lo_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        bound_reg     <= bound_next;
        res_found_reg <= res_found_next;
        res_pos_reg   <= res_pos_next;
        res_ovf_reg   <= res_ovf_next;
        if (cmd.capture) begin
            key_reg <= value;
        end
        if (cmd.head_load) begin
            head_reg <= rdata;
        end
        if (cmd.out_load) begin
            out_found_reg <= res_found_reg;
            out_pos_reg   <= res_pos_reg;
            out_ovf_reg   <= res_ovf_reg;
        end
    end

    assign status.count_zero  = (count_reg == '0);
    assign status.count_full  = (count_reg == CW'(DEPTH));
    assign status.lo_lt_hi    = (lo_reg < hi_reg);
    assign status.lo_lt_bound = (lo_reg < bound_reg);

    assign m_tdata = {{(rsas_pkg::M_TDATA_W - rsas_pkg::POS_W - 1){1'b0}},
                      out_pos_reg, out_found_reg};
    assign m_tuser = out_ovf_reg;

endmodule

[rtl/core/rsas_ctrl.sv]
// ----------------------------------------------------------------------------
// Rotated sorted array search: controller
// Sequences loads and the two binary searches and owns the result valid.
// ----------------------------------------------------------------------------
module rsas_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  rsas_pkg::op_t        s_op,
    input  logic                 s_first,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  rsas_pkg::dp_status_t status,
    output rsas_pkg::dp_cmd_t    cmd
);

    rsas_pkg::state_t state_reg, state_next;
    logic m_tvalid_reg, m_tvalid_next;
    logic out_free;

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            rsas_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_op == rsas_pkg::OP_SEARCH) begin
                        state_next = status.count_zero ? rsas_pkg::ST_EMIT
                                                       : rsas_pkg::ST_HEAD;
                    end else if (!s_first && status.count_full) begin
                        state_next = rsas_pkg::ST_EMIT;
                    end
                end
            end
            rsas_pkg::ST_HEAD:    state_next = rsas_pkg::ST_ROT_RD;
            rsas_pkg::ST_ROT_RD:  state_next = status.lo_lt_hi ? rsas_pkg::ST_ROT_CMP
                                                               : rsas_pkg::ST_PICK;
            rsas_pkg::ST_ROT_CMP: state_next = rsas_pkg::ST_ROT_RD;
            rsas_pkg::ST_PICK:    state_next = rsas_pkg::ST_LB_RD;
            rsas_pkg::ST_LB_RD:   state_next = status.lo_lt_hi ? rsas_pkg::ST_LB_CMP
                                                               : rsas_pkg::ST_FIN_RD;
            rsas_pkg::ST_LB_CMP:  state_next = rsas_pkg::ST_LB_RD;
            rsas_pkg::ST_FIN_RD:  state_next = status.lo_lt_bound ? rsas_pkg::ST_FIN_CMP
                                                                  : rsas_pkg::ST_EMIT;
            rsas_pkg::ST_FIN_CMP: state_next = rsas_pkg::ST_EMIT;
            rsas_pkg::ST_EMIT: begin
                if (out_free) begin
                    state_next = rsas_pkg::ST_IDLE;
                end
            end
            default:              state_next = rsas_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd        = '0;
        cmd.rd_sel = rsas_pkg::RD_ZERO;
        unique case (state_reg)
            rsas_pkg::ST_IDLE: begin
                // Element zero is read here so that it is ready in ST_HEAD.
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    if (s_op == rsas_pkg::OP_SEARCH) begin
                        cmd.res_clear = 1'b1;
                    end else if (s_first || !status.count_full) begin
                        cmd.wr = 1'b1;
                    end else begin
                        cmd.res_ovf = 1'b1;
                    end
                end
            end
            rsas_pkg::ST_HEAD: begin
                cmd.head_load = 1'b1;
                cmd.rot_init  = 1'b1;
            end
            rsas_pkg::ST_ROT_RD:  cmd.rd_sel = rsas_pkg::RD_MID;
            rsas_pkg::ST_ROT_CMP: cmd.rot_step = 1'b1;
            rsas_pkg::ST_PICK:    cmd.pick = 1'b1;
            rsas_pkg::ST_LB_RD:   cmd.rd_sel = rsas_pkg::RD_MID;
            rsas_pkg::ST_LB_CMP:  cmd.lb_step = 1'b1;
            rsas_pkg::ST_FIN_RD:  cmd.rd_sel = rsas_pkg::RD_LO;
            rsas_pkg::ST_FIN_CMP: cmd.res_check = 1'b1;
            rsas_pkg::ST_EMIT:    cmd.out_load = out_free;
            default:              cmd.rd_sel = rsas_pkg::RD_ZERO;
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= rsas_pkg::ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = (state_reg == rsas_pkg::ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

endmodule

[tb/rotated_sorted_array_search_top_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Rotated sorted array search: regression testbench
// Loads rotated ascending arrays through the request channel and searches
// them, checking every result against an in-bench copy of the search. Runs
// directed corner cases, a completely full store with dropped loads, a long
// result-side hold-off, and random request streams under four idling mixes.
// ----------------------------------------------------------------------------
module rotated_sorted_array_search_top_test;

    localparam int STORE_DEPTH   = rsas_pkg::DEPTH_DEF;
    // Long enough for a full-store search to finish.
    localparam int SETTLE_CYCLES = 64;
    localparam int HOLD_CYCLES   = 400;
    localparam int FULL_ROTATION = 300;
    // Watchdog limit, in nanoseconds.
    localparam int LIMIT_NS      = 20_000_000;

    // One result as the block reports it.
    typedef struct packed {
        logic                       found;
        logic [rsas_pkg::POS_W-1:0] position;
        logic                       overflow;
    } answer_t;

    logic                           aclk     = 1'b0;
    logic                           aresetn  = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [rsas_pkg::S_TDATA_W-1:0] s_tdata  = '0;   // value[31:0]
    logic [rsas_pkg::S_TUSER_W-1:0] s_tuser  = '0;   // [0] op, [1] first
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [rsas_pkg::M_TDATA_W-1:0] m_tdata;         // [0] found, [10:1] position
    logic [rsas_pkg::M_TUSER_W-1:0] m_tuser;         // [0] overflow

    // The bench's own copy of the array, kept in step with accepted loads.
    logic signed [rsas_pkg::DATA_W-1:0] array_copy [STORE_DEPTH];
    int unsigned                        array_len = 0;

    // Results still owed by the block, oldest first.
    answer_t answers_due [$];

    int   mismatches     = 0;
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    logic hold_on        = 1'b0;
    event hold_start;

    rotated_sorted_array_search_top #(
        .DEPTH (STORE_DEPTH)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // 20 ns clock period.
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Works out what one accepted request should produce and updates the
    // array copy. A load normally produces nothing; a non-first load into a
    // full store is dropped and reported; a search always answers. The search
    // mirrors the block: first the rotation point (first index below element
    // 0), then a lower bound in the half that the target belongs to.
    function automatic void search_answer(input rsas_pkg::op_t op,
                                          input logic signed [rsas_pkg::DATA_W-1:0] value,
                                          input logic first, output bit emits,
                                          output answer_t ans);
        int unsigned                        lo, hi, mid, bound, pivot;
        logic signed [rsas_pkg::DATA_W-1:0] head;
        ans   = '0;
        emits = 1'b0;
        if (op == rsas_pkg::OP_LOAD) begin
            if (first)
                array_len = 0;
            if (array_len >= STORE_DEPTH) begin
                ans.overflow = 1'b1;
                emits        = 1'b1;
            end else begin
                array_copy[array_len] = value;
                array_len++;
            end
        end else begin
            emits = 1'b1;
            if (array_len > 0) begin
                head = array_copy[0];
                lo   = 0;
                hi   = array_len;
                while (lo < hi) begin
                    mid = lo + (hi - lo) / 2;
                    if (array_copy[mid] >= head)
                        lo = mid + 1;
                    else
                        hi = mid;
                end
                pivot = lo;
                // Targets at or above element 0 live before the rotation point.
                if (value >= head) begin
                    lo    = 0;
                    bound = pivot;
                end else begin
                    lo    = pivot;
                    bound = array_len;
                end
                hi = bound;
                while (lo < hi) begin
                    mid = lo + (hi - lo) / 2;
                    if (array_copy[mid] < value)
                        lo = mid + 1;
                    else
                        hi = mid;
                end
                if (lo < bound && array_copy[lo] == value) begin
                    ans.found    = 1'b1;
                    ans.position = lo[rsas_pkg::POS_W-1:0];
                end
            end
        end
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("%0t ns: mismatch: %s", $time, what);
    endtask

    // Offers one request, waits for the handshake and records what it owes.
    // Always called and left at a falling edge, so tvalid is written at
    // most once per time step.
    task automatic send_request(input rsas_pkg::op_t op,
                                input logic signed [rsas_pkg::DATA_W-1:0] value,
                                input logic first);
        bit      emits;
        answer_t ans;
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tuser  <= {first, op};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        search_answer(op, value, first, emits, ans);
        if (emits)
            answers_due.push_back(ans);
        @(negedge aclk);
    endtask

    // Loads a whole array, the first element restarting it.
    task automatic load_list(input logic signed [rsas_pkg::DATA_W-1:0] items [$]);
        foreach (items[i])
            send_request(rsas_pkg::OP_LOAD, items[i], i == 0);
    endtask

    // Stops offering requests until every owed result has arrived, then lets
    // the block finish any search still in flight.
    task automatic wait_for_answers();
        s_tvalid <= 1'b0;
        while (answers_due.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Element value for a given rank in the full-store ladder; spaced out so
    // that values between rungs are certain misses.
    function automatic logic signed [rsas_pkg::DATA_W-1:0] ladder_value(input int rank);
        return 32'sh8000_0001 + (rank << 22);
    endfunction

    // Searches straight after reset see an empty array. The first flag is
    // meaningless on a search and must not disturb anything.
    task automatic test_empty_search();
        send_request(rsas_pkg::OP_SEARCH, 32'sh0000_0000, 1'b0);
        send_request(rsas_pkg::OP_SEARCH, 32'sh8000_0000, 1'b1);
        send_request(rsas_pkg::OP_SEARCH, 32'sh7fff_ffff, 1'b0);
        wait_for_answers();
    endtask

    // A one-element array, a rotation that straddles both signed extremes,
    // and a list of duplicates whose lower bound must land on the first copy.
    task automatic test_small_lists();
        load_list('{32'sd7});
        send_request(rsas_pkg::OP_SEARCH, 32'sd7, 1'b0);
        send_request(rsas_pkg::OP_SEARCH, 32'sd8, 1'b0);

        load_list('{32'sd5, 32'sd100, 32'sh7fff_ffff, 32'sh8000_0000, -32'sd7, 32'sd0});
        send_request(rsas_pkg::OP_SEARCH, 32'sh7fff_ffff, 1'b0);
        send_request(rsas_pkg::OP_SEARCH, 32'sh8000_0000, 1'b1);
        send_request(rsas_pkg::OP_SEARCH, 32'sd0, 1'b0);
        send_request(rsas_pkg::OP_SEARCH, 32'sd5, 1'b0);
        send_request(rsas_pkg::OP_SEARCH, 32'sd6, 1'b0);
        send_request(rsas_pkg::OP_SEARCH, -32'sd8, 1'b0);

        load_list('{32'sd3, 32'sd3, 32'sd3, 32'sd1, 32'sd1});
        send_request(rsas_pkg::OP_SEARCH, 32'sd3, 1'b0);
        send_request(rsas_pkg::OP_SEARCH, 32'sd1, 1'b0);
        wait_for_answers();
    endtask

    // Fills every entry, so hits come back with the top position bits set,
    // then pushes loads into the full store (dropped and flagged) and shows
    // that a first load still restarts the array.
    task automatic test_full_store();
        for (int i = 0; i < STORE_DEPTH; i++)
            send_request(rsas_pkg::OP_LOAD,
                         ladder_value((i + FULL_ROTATION) % STORE_DEPTH), i == 0);
        send_request(rsas_pkg::OP_SEARCH, ladder_value(0), 1'b0);
        send_request(rsas_pkg::OP_SEARCH, ladder_value(723), 1'b0);
        send_request(rsas_pkg::OP_SEARCH, ladder_value(1023), 1'b0);
        send_request(rsas_pkg::OP_SEARCH, ladder_value(299), 1'b0);
        send_request(rsas_pkg::OP_SEARCH, ladder_value(300), 1'b0);
        send_request(rsas_pkg::OP_SEARCH, ladder_value(811), 1'b0);
        send_request(rsas_pkg::OP_SEARCH, ladder_value(812), 1'b0);
        send_request(rsas_pkg::OP_SEARCH, ladder_value(500) + 1, 1'b0);
        send_request(rsas_pkg::OP_SEARCH, 32'sh7fff_ffff, 1'b0);
        send_request(rsas_pkg::OP_SEARCH, 32'sh8000_0000, 1'b0);
        send_request(rsas_pkg::OP_LOAD, $urandom, 1'b0);
        send_request(rsas_pkg::OP_LOAD, $urandom, 1'b0);
        send_request(rsas_pkg::OP_SEARCH, ladder_value(299), 1'b0);
        send_request(rsas_pkg::OP_LOAD, 32'sd42, 1'b1);
        send_request(rsas_pkg::OP_SEARCH, 32'sd42, 1'b0);
        send_request(rsas_pkg::OP_LOAD, 32'sd43, 1'b0);
        send_request(rsas_pkg::OP_SEARCH, 32'sd43, 1'b0);
        wait_for_answers();
    endtask

    // The result side refuses everything for a long stretch while searches
    // keep coming, so the block's output register fills and the request
    // channel has to stall.
    task automatic test_pressure();
        -> hold_start;
        for (int i = 0; i < 24; i++)
            send_request(rsas_pkg::OP_SEARCH,
                         ($urandom_range(2) == 0) ? $urandom : 42 + $urandom_range(1),
                         1'($urandom_range(1)));
        wait_for_answers();
    endtask

    // Random traffic. Most of it is well-formed: a sorted list (sometimes
    // dense with repeats), rotated, loaded from a first element and then
    // searched for members, near misses and extremes. The rest is stray
    // loads that may break the ordering and searches for arbitrary targets.
    task automatic test_random_phase(input int idle_pct, input int stall_pct, input int items);
        logic signed [rsas_pkg::DATA_W-1:0] list [$];
        logic signed [rsas_pkg::DATA_W-1:0] pick, held;
        int sent, kind, n, rot, j, dense;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        while (sent < items) begin
            kind = $urandom_range(99);
            if (kind < 75) begin
                n     = ($urandom_range(9) == 0) ? $urandom_range(25, 80) : $urandom_range(1, 24);
                dense = ($urandom_range(3) == 0);
                list.delete();
                for (int i = 0; i < n; i++)
                    list.push_back(dense ? $urandom_range(60) - 30 : $urandom);
                // Insertion sort, ascending as signed values.
                for (int i = 1; i < n; i++) begin
                    held = list[i];
                    j    = i;
                    while (j > 0 && list[j-1] > held) begin
                        list[j] = list[j-1];
                        j--;
                    end
                    list[j] = held;
                end
                rot = $urandom_range(n - 1);
                repeat (rot) list.push_back(list.pop_front());
                load_list(list);
                sent += n;
                repeat ($urandom_range(1, 6)) begin
                    pick = list[$urandom_range(n - 1)];
                    case ($urandom_range(9))
                        6:       pick = pick + 1;
                        7:       pick = pick - 1;
                        8:       pick = $urandom_range(1) ? 32'sh7fff_ffff : 32'sh8000_0000;
                        9:       pick = $urandom;
                        default: ;
                    endcase
                    send_request(rsas_pkg::OP_SEARCH, pick, 1'($urandom_range(1)));
                    sent++;
                end
            end else if (kind < 90) begin
                repeat ($urandom_range(1, 8)) begin
                    send_request(rsas_pkg::OP_LOAD, $urandom, $urandom_range(7) == 0);
                    sent++;
                end
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    send_request(rsas_pkg::OP_SEARCH, $urandom, 1'($urandom_range(1)));
                    sent++;
                end
            end
        end
        wait_for_answers();
    endtask

    // Result-side readiness, changed at the falling edge.
    always @(negedge aclk) begin
        if (hold_on)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // The long hold-off, counted here in clock cycles.
    initial forever begin
        @(hold_start);
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge aclk);
        hold_on <= 1'b0;
    end

    // Every result taken at a rising edge is matched against the oldest
    // owed one, field by field.
    always @(posedge aclk) begin
        answer_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.found    = m_tdata[0];
            got.position = m_tdata[rsas_pkg::POS_W:1];
            got.overflow = m_tuser[0];
            if (answers_due.size() == 0) begin
                report_mismatch($sformatf("unexpected result found=%b position=%0d overflow=%b",
                                          got.found, got.position, got.overflow));
            end else begin
                want = answers_due.pop_front();
                if (got.found !== want.found)
                    report_mismatch($sformatf("found %b, wanted %b", got.found, want.found));
                if (got.position !== want.position)
                    report_mismatch($sformatf("position %0d, wanted %0d",
                                              got.position, want.position));
                if (got.overflow !== want.overflow)
                    report_mismatch($sformatf("overflow %b, wanted %b",
                                              got.overflow, want.overflow));
            end
        end
    end

    initial begin
        // Reset is held from time zero and released at a falling edge.
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_empty_search();
        test_small_lists();
        test_full_store();
        test_pressure();
        test_random_phase(0, 0, 95);
        test_random_phase(73, 0, 95);
        test_random_phase(0, 73, 95);
        test_random_phase(18, 18, 95);

        if (mismatches == 0 && answers_due.size() == 0)
            $display("rotated_sorted_array_search_top regression: pass");
        else
            $display("rotated_sorted_array_search_top regression: fail");
        $finish;
    end

    // Watchdog in case the block stops answering.
    initial begin
        #(LIMIT_NS);
        $display("rotated_sorted_array_search_top regression: fail");
        $finish;
    end

endmodule

[rotated_sorted_array_search_top.f]
rtl/core/rsas_pkg.sv
rtl/core/rsas_ram.sv
rtl/core/rsas_dp.sv
rtl/core/rsas_ctrl.sv
rtl/core/rotated_sorted_array_search_top.sv
tb/rotated_sorted_array_search_top_test.sv
